FILE: rtl/core/interval_timer_overrun_counter_assert.svh
// Assertion macros for the interval timer with overrun count.
`ifndef INTERVAL_TIMER_OVERRUN_COUNTER_ASSERT_SVH
`define INTERVAL_TIMER_OVERRUN_COUNTER_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off during rst.
`define ITOC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and held off during rst.
`define ITOC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/itoc_pkg.sv
// Shared constants and codes for the interval timer with overrun count.
`default_nettype none
package itoc_pkg;
  localparam int TIME_BITS_DEF = 64;
  localparam int COUNT_W       = 64;
  localparam int FIELD_W       = 64;
  localparam int S_TDATA_W     = 256;
  localparam int S_TUSER_W     = 3;
  localparam int M_TDATA_W     = 200;
  localparam int M_TUSER_W     = 1;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_SET  = 2'd1;
  localparam logic [1:0] OP_GET  = 2'd2;
  localparam logic [1:0] OP_READ = 2'd3;
endpackage
`default_nettype wire

FILE: rtl/core/interval_timer_overrun_counter.sv
// Interval timer with overrun count: sequencer around one shared serial divider.
// Each item is latched in idle, then passes check, the divide and update when a
// refresh is due, post and finish; a set that re-arms returns to check and may divide again.
// One transaction at a time; the restoring divider, one quotient bit per cycle,
// does the refresh. The result register lets the next item be taken while a
// result is still held downstream.
// Synchronous reset disarms the timer, clears period, deadline, count and select.
`default_nettype none
module interval_timer_overrun_counter #(
  parameter int TIME_BITS = itoc_pkg::TIME_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic                           cfg_data,      // clock_select
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // mono_time[63:0], real_time[127:64], new_value[191:128], new_interval[255:192]
  input  wire logic [itoc_pkg::S_TDATA_W-1:0] s_tdata,
  // op[1:0], absolute_mode[2]
  input  wire logic [itoc_pkg::S_TUSER_W-1:0] s_tuser,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // expiry_count[63:0], remaining_time[127:64], interval_value[191:128],
  // became_readable[192], readable[193], zero padding[199:194]
  output logic [itoc_pkg::M_TDATA_W-1:0]      m_tdata,
  // status[0]
  output logic [itoc_pkg::M_TUSER_W-1:0]      m_tuser
);

  localparam int CNT_W   = $clog2(TIME_BITS);
  localparam int COUNT_W = itoc_pkg::COUNT_W;
  localparam int FW      = itoc_pkg::FIELD_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_UPD   = 3'd3;
  localparam logic [2:0] S_POST  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0]           state;
  logic                 clock_sel;
  logic                 running;
  logic [TIME_BITS-1:0] period;
  logic [TIME_BITS-1:0] deadline;
  logic [COUNT_W-1:0]   pend;

  logic [TIME_BITS-1:0] now_r;
  logic [TIME_BITS-1:0] nval_r;
  logic [TIME_BITS-1:0] nint_r;
  logic [1:0]           op_r;
  logic                 absm_r;
  logic                 pass;
  logic                 before_zero;

  logic [TIME_BITS-1:0] rem;
  logic [TIME_BITS-1:0] quo;
  logic [CNT_W-1:0]     cnt;

  logic                 res_status;
  logic [COUNT_W-1:0]   res_count;
  logic [TIME_BITS-1:0] res_remain;
  logic [TIME_BITS-1:0] res_ival;
  logic                 res_became;

  // Divider step: shift one dividend bit into the partial remainder, try subtract.
  logic [TIME_BITS:0]   trial;
  logic                 borrow;
  logic [TIME_BITS-1:0] rem_next;
  assign trial    = {rem, quo[TIME_BITS-1]} - {1'b0, period};
  assign borrow   = trial[TIME_BITS];
  assign rem_next = borrow ? {rem[TIME_BITS-2:0], quo[TIME_BITS-1]} : trial[TIME_BITS-1:0];

  // Missed periods are quotient + 1, held at the 64-bit maximum.
  logic [COUNT_W:0]     missed_sum;
  logic [COUNT_W-1:0]   missed;
  logic [COUNT_W:0]     pend_sum;
  logic [COUNT_W-1:0]   pend_plus;
  assign missed_sum = (COUNT_W + 1)'(quo) + (COUNT_W + 1)'(1);
  assign missed     = missed_sum[COUNT_W] ? '1 : missed_sum[COUNT_W-1:0];
  assign pend_sum   = {1'b0, pend} + {1'b0, missed};
  assign pend_plus  = pend_sum[COUNT_W] ? '1 : pend_sum[COUNT_W-1:0];

  // Old deadline plus missed * period equals now - remainder + period, so no
  // multiply is needed; a carry out means the time range overflowed.
  logic [TIME_BITS:0]   roll_sum;
  logic [TIME_BITS-1:0] roll_deadline;
  assign roll_sum      = ({1'b0, now_r} - {1'b0, rem}) + {1'b0, period};
  assign roll_deadline = roll_sum[TIME_BITS] ? '1 : roll_sum[TIME_BITS-1:0];

  logic [COUNT_W-1:0]   pend_inc;
  assign pend_inc = (pend == '1) ? pend : pend + COUNT_W'(1);

  logic [TIME_BITS:0]   rel_sum;
  logic [TIME_BITS-1:0] rel_deadline;
  assign rel_sum      = {1'b0, now_r} + {1'b0, nval_r};
  assign rel_deadline = rel_sum[TIME_BITS] ? '1 : rel_sum[TIME_BITS-1:0];

  logic fired;
  assign fired = before_zero && (pend != '0);

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      clock_sel <= 1'b0;
      running   <= 1'b0;
      period    <= '0;
      deadline  <= '0;
      pend      <= '0;
      pass      <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        clock_sel <= cfg_data;
      end
      if (m_tvalid && m_tready && (state != S_FIN)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            now_r  <= clock_sel ? s_tdata[FW +: TIME_BITS] : s_tdata[0 +: TIME_BITS];
            nval_r <= s_tdata[2*FW +: TIME_BITS];
            nint_r <= s_tdata[3*FW +: TIME_BITS];
            op_r   <= s_tuser[1:0];
            absm_r <= s_tuser[2];
            pass   <= 1'b0;
            state  <= S_CHECK;
          end
        end
        S_CHECK: begin
          before_zero <= (pend == '0);
          if (running && (now_r >= deadline)) begin
            if (period == '0) begin
              pend     <= pend_inc;
              running  <= 1'b0;
              deadline <= '0;
              state    <= S_POST;
            end else begin
              rem   <= '0;
              quo   <= now_r - deadline;
              cnt   <= CNT_W'(TIME_BITS - 1);
              state <= S_DIV;
            end
          end else begin
            state <= S_POST;
          end
        end
        S_DIV: begin
          rem <= rem_next;
          quo <= {quo[TIME_BITS-2:0], ~borrow};
          if (cnt == '0) begin
            state <= S_UPD;
          end else begin
            cnt <= cnt - CNT_W'(1);
          end
        end
        S_UPD: begin
          pend     <= pend_plus;
          deadline <= roll_deadline;
          state    <= S_POST;
        end
        S_POST: begin
          if (!pass) begin
            res_became <= fired;
            res_ival   <= period;
            res_remain <= (running && (deadline > now_r)) ? deadline - now_r : '0;
            res_status <= 1'b0;
            res_count  <= '0;
            unique case (op_r)
              itoc_pkg::OP_SET: begin
                period <= nint_r;
                pend   <= '0;
                if (nval_r == '0) begin
                  running  <= 1'b0;
                  deadline <= '0;
                  state    <= S_FIN;
                end else begin
                  deadline <= absm_r ? nval_r : rel_deadline;
                  running  <= 1'b1;
                  pass     <= 1'b1;
                  state    <= S_CHECK;
                end
              end
              itoc_pkg::OP_READ: begin
                if (pend != '0) begin
                  res_count <= pend;
                  pend      <= '0;
                end else begin
                  res_status <= 1'b1;
                end
                state <= S_FIN;
              end
              itoc_pkg::OP_TICK, itoc_pkg::OP_GET: begin
                state <= S_FIN;
              end
            endcase
          end else begin
            if (fired) begin
              res_became <= 1'b1;
            end
            state <= S_FIN;
          end
        end
        S_FIN: begin
          // Wait here only while the previous result is still held downstream.
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {6'b0, (pend != '0), res_became, FW'(res_ival),
                         FW'(res_remain), res_count};
            m_tuser  <= res_status;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`include "interval_timer_overrun_counter_assert.svh"

  `ITOC_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready after accept")
  `ITOC_ASSERT_NOW(a_disarmed_zero, !running, deadline == '0, "disarmed with a deadline")
  `ITOC_ASSERT_NOW(a_empty_read_zero, m_tvalid && m_tuser[0], m_tdata[COUNT_W-1:0] == '0,
                   "empty read returned a count")

endmodule
`default_nettype wire

FILE: tb/sv/interval_timer_overrun_checker.sv
// Checker for the interval timer: predicts every result and compares it on the output stream.
module interval_timer_overrun_checker (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  input  wire logic                           cfg_ready,
  input  wire logic                           cfg_data,
  input  wire logic                           s_tvalid,
  input  wire logic                           s_tready,
  // mono_time, real_time, new_value, new_interval
  input  wire logic [itoc_pkg::S_TDATA_W-1:0] s_tdata,
  // op, absolute_mode
  input  wire logic [itoc_pkg::S_TUSER_W-1:0] s_tuser,
  input  wire logic                           m_tvalid,
  input  wire logic                           m_tready,
  // expiry_count, remaining_time, interval_value, became_readable, readable, padding
  input  wire logic [itoc_pkg::M_TDATA_W-1:0] m_tdata,
  // status
  input  wire logic [itoc_pkg::M_TUSER_W-1:0] m_tuser,
  output int                                  errors,
  output int                                  backlog
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] TMAX = {64{1'b1}} >> (64 - itoc_pkg::TIME_BITS_DEF);
  localparam logic [63:0] CMAX = {64{1'b1}};

  typedef struct packed {
    logic        status;
    logic [63:0] count;
    logic [63:0] remain;
    logic [63:0] interval;
    logic        became;
    logic        readable;
  } timer_result_t;

  // Shadow copy of the timer state.
  logic        use_realtime;
  logic [63:0] period_ns;
  logic [63:0] deadline_ns;
  logic [63:0] overruns;
  logic        armed;

  timer_result_t pending_results[$];

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] top);
    if (a > top || b > top - a) return top;
    return a + b;
  endfunction

  // Counts the periods that have elapsed up to now and moves the deadline on, or disarms a one-shot timer.
  // Returns whether the overrun count rose from zero.
  function automatic logic catch_up(input logic [63:0] now);
    logic [63:0] prior;
    logic [63:0] missed;
    prior = overruns;
    if (!armed || now < deadline_ns) return 1'b0;
    if (period_ns == 0) begin
      overruns = sat_add(overruns, 64'd1, CMAX);
      armed = 1'b0;
      deadline_ns = '0;
    end else begin
      missed = sat_add((now - deadline_ns) / period_ns, 64'd1, CMAX);
      overruns = sat_add(overruns, missed, CMAX);
      // Fall back to now plus one period when the advanced deadline would not fit.
      if (missed > TMAX / period_ns || deadline_ns > TMAX - missed * period_ns)
        deadline_ns = sat_add(now, period_ns, TMAX);
      else
        deadline_ns = deadline_ns + missed * period_ns;
    end
    return prior == 0 && overruns != 0;
  endfunction

  function automatic timer_result_t predict(input logic [itoc_pkg::S_TDATA_W-1:0] data,
                                            input logic [itoc_pkg::S_TUSER_W-1:0] user);
    logic [1:0]    op;
    logic          absm;
    logic [63:0]   now;
    logic [63:0]   nval;
    logic [63:0]   nint;
    timer_result_t r;
    op   = user[1:0];
    absm = user[2];
    now  = (use_realtime ? data[127:64] : data[63:0]) & TMAX;
    nval = data[191:128] & TMAX;
    nint = data[255:192] & TMAX;
    r = '0;
    r.became   = catch_up(now);
    r.interval = period_ns;
    if (armed && deadline_ns > now) r.remain = deadline_ns - now;
    if (op == itoc_pkg::OP_SET) begin
      period_ns = nint;
      overruns  = '0;
      if (nval == 0) begin
        armed = 1'b0;
        deadline_ns = '0;
      end else begin
        deadline_ns = absm ? nval : sat_add(now, nval, TMAX);
        armed = 1'b1;
        // A deadline that is already due fires at once.
        if (catch_up(now)) r.became = 1'b1;
      end
    end else if (op == itoc_pkg::OP_READ) begin
      if (overruns != 0) begin
        r.count  = overruns;
        overruns = '0;
      end else begin
        r.status = 1'b1;
      end
    end
    r.readable = overruns != 0;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 10)
        $display("%0t: %s mismatch: expected %h, got %h", $realtime, name, want, got);
    end
  endtask

  initial errors = 0;

  always @(posedge clk) begin : monitor
    timer_result_t want;
    if (rst) begin
      use_realtime = 1'b0;
      period_ns    = '0;
      deadline_ns  = '0;
      overruns     = '0;
      armed        = 1'b0;
      pending_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) use_realtime = cfg_data;
      if (s_tvalid && s_tready) pending_results.push_back(predict(s_tdata, s_tuser));
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: result transaction with no expectation: tdata %h tuser %h",
                     $realtime, m_tdata, m_tuser);
        end else begin
          want = pending_results.pop_front();
          check_field("status", 64'(want.status), 64'(m_tuser[0]));
          check_field("expiry_count", want.count, m_tdata[63:0]);
          check_field("remaining_time", want.remain, m_tdata[127:64]);
          check_field("interval_value", want.interval, m_tdata[191:128]);
          check_field("became_readable", 64'(want.became), 64'(m_tdata[192]));
          check_field("readable", 64'(want.readable), 64'(m_tdata[193]));
        end
      end
    end
    backlog <= pending_results.size();
  end
endmodule

FILE: tb/sv/interval_timer_overrun_counter_tb.sv
// Testbench top for the interval timer: clock, reset, stimulus and the final verdict.
module interval_timer_overrun_counter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          STALL_LIMIT = 4000;
  localparam logic [63:0] MAX64       = {64{1'b1}};

  logic                           clk;
  logic                           rst;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic                           cfg_data;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [itoc_pkg::S_TDATA_W-1:0] s_tdata;
  logic [itoc_pkg::S_TUSER_W-1:0] s_tuser;
  logic                           m_tvalid;
  logic                           m_tready;
  logic [itoc_pkg::M_TDATA_W-1:0] m_tdata;
  logic [itoc_pkg::M_TUSER_W-1:0] m_tuser;
  int                             errors;
  int                             backlog;

  int          idle_pct;
  int          quiet_cycles;
  logic        cur_sel;
  logic [63:0] mono_now;
  logic [63:0] real_now;

  interval_timer_overrun_counter u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  interval_timer_overrun_checker u_checker (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .errors   (errors),
    .backlog  (backlog)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (!rst) m_tready <= $urandom_range(0, 99) >= idle_pct;
  end

  // Ends the run if no transaction moves on any channel for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("interval_timer_overrun_counter_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic send_item(input logic [1:0] op, input logic [63:0] mono,
                           input logic [63:0] rt, input logic [63:0] nval,
                           input logic [63:0] nint, input logic absm);
    int gap;
    if ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      // Mostly short gaps, now and then a longer one that can outlast a whole divide.
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 160) : $urandom_range(1, 3);
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {nint, nval, rt, mono};
    s_tuser  <= {absm, op};
    do @(posedge clk); while (!s_tready);
  endtask

  // Drains all results, then writes the clock select.
  task automatic write_select(input logic sel);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (backlog != 0);
    cfg_valid <= 1'b1;
    cfg_data  <= sel;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_sel = sel;
  endtask

  // Directed items run on the monotonic clock.
  task automatic send_mono(input logic [1:0] op, input logic [63:0] now,
                           input logic [63:0] nval, input logic [63:0] nint,
                           input logic absm);
    send_item(op, now, rand64(), nval, nint, absm);
  endtask

  task automatic random_item();
    int          pick;
    logic [1:0]  op;
    logic        absm;
    logic [63:0] now;
    logic [63:0] nval;
    logic [63:0] nint;
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      mono_now = rand64();
      real_now = rand64();
    end else if (pick < 6) begin
      mono_now -= 64'($urandom_range(0, 300));
      real_now -= 64'($urandom_range(0, 300));
    end else if (pick < 12) begin
      mono_now += 64'($urandom_range(0, 200000));
      real_now += 64'($urandom_range(0, 200000));
    end else begin
      mono_now += 64'($urandom_range(0, 300));
      real_now += 64'($urandom_range(0, 300));
    end
    now  = cur_sel ? real_now : mono_now;
    pick = $urandom_range(0, 99);
    op   = (pick < 35) ? itoc_pkg::OP_TICK : (pick < 55) ? itoc_pkg::OP_SET :
           (pick < 75) ? itoc_pkg::OP_GET : itoc_pkg::OP_READ;
    absm = 1'($urandom_range(0, 1));
    nval = rand64();
    nint = rand64();
    if (op == itoc_pkg::OP_SET) begin
      // Mostly deadlines and periods close to the current time, so that they expire.
      pick = $urandom_range(0, 99);
      if (pick < 8)
        nval = '0;
      else if (pick >= 16)
        nval = absm ? now + 64'($urandom_range(0, 2000)) - 64'd500
                    : 64'($urandom_range(1, 2000));
      pick = $urandom_range(0, 99);
      if (pick < 20)
        nint = '0;
      else if (pick >= 26)
        nint = 64'($urandom_range(1, 500));
    end
    send_item(op, mono_now, real_now, nval, nint, absm);
  endtask

  initial begin : stimulus
    int phase;
    rst       <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_data  <= 1'b0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= '0;
    m_tready  <= 1'b0;
    idle_pct = 25;
    cur_sel  = 1'b0;
    mono_now = '0;
    real_now = 64'($urandom_range(0, 100000));
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    write_select(1'b0);
    send_mono(itoc_pkg::OP_TICK, 64'd0, MAX64, MAX64, 1'b1);
    send_mono(itoc_pkg::OP_READ, 64'd10, 64'd0, 64'd0, 1'b0);
    send_mono(itoc_pkg::OP_GET, 64'd20, 64'd0, 64'd0, 1'b0);
    // One-shot timer: arm, look, expire, read.
    send_mono(itoc_pkg::OP_SET, 64'd1000, 64'd100, 64'd0, 1'b0);
    send_mono(itoc_pkg::OP_GET, 64'd1050, 64'd0, 64'd0, 1'b0);
    send_mono(itoc_pkg::OP_TICK, 64'd1100, 64'd0, 64'd0, 1'b0);
    send_mono(itoc_pkg::OP_READ, 64'd1101, 64'd0, 64'd0, 1'b0);
    // Periodic timer that misses several periods.
    send_mono(itoc_pkg::OP_SET, 64'd2000, 64'd10, 64'd7, 1'b0);
    send_mono(itoc_pkg::OP_TICK, 64'd2100, 64'd0, 64'd0, 1'b0);
    send_mono(itoc_pkg::OP_READ, 64'd2100, 64'd0, 64'd0, 1'b0);
    // Absolute deadline already in the past fires at once.
    send_mono(itoc_pkg::OP_SET, 64'd2200, 64'd1500, 64'd3, 1'b1);
    send_mono(itoc_pkg::OP_GET, 64'd2201, 64'd0, 64'd0, 1'b0);
    // A zero value disarms.
    send_mono(itoc_pkg::OP_SET, 64'd2300, 64'd0, MAX64, 1'b1);
    // Relative set whose deadline saturates.
    send_mono(itoc_pkg::OP_SET, 64'd5, MAX64, 64'd0, 1'b0);
    send_mono(itoc_pkg::OP_GET, 64'd5, 64'd0, 64'd0, 1'b0);
    // Huge overrun, then the count saturates.
    send_mono(itoc_pkg::OP_SET, 64'd0, 64'd1, 64'd1, 1'b1);
    send_mono(itoc_pkg::OP_TICK, MAX64, 64'd0, 64'd0, 1'b0);
    send_mono(itoc_pkg::OP_TICK, MAX64, 64'd0, 64'd0, 1'b0);
    send_mono(itoc_pkg::OP_READ, MAX64, 64'd0, 64'd0, 1'b0);
    // The advanced deadline does not fit and falls back to now plus the period.
    send_mono(itoc_pkg::OP_SET, MAX64 - 64'd20, MAX64 - 64'd10, 64'h8000_0000_0000_0000,
              1'b1);
    send_mono(itoc_pkg::OP_TICK, MAX64, 64'd0, 64'd0, 1'b0);
    send_mono(itoc_pkg::OP_GET, 64'd0, 64'd0, 64'd0, 1'b0);
    send_mono(itoc_pkg::OP_READ, 64'd0, 64'd0, 64'd0, 1'b0);
    send_mono(itoc_pkg::OP_SET, MAX64, MAX64, MAX64, 1'b1);
    send_mono(itoc_pkg::OP_TICK, 64'd0, 64'd0, 64'd0, 1'b0);

    for (phase = 0; phase < 4; phase++) begin
      write_select(phase % 2 == 0);
      idle_pct = (phase == 2) ? 0 : 25;
      repeat (225) random_item();
    end
    s_tvalid <= 1'b0;
    idle_pct = 25;

    do @(posedge clk); while (backlog != 0);
    repeat (150) @(posedge clk);
    if (errors == 0)
      $display("interval_timer_overrun_counter_tb: clean");
    else
      $display("interval_timer_overrun_counter_tb: errors");
    $finish;
  end
endmodule
